/* rtl/in_plane_direction_cramer_solve_defines.svh */
// Assertion macros shared by the in-plane direction solver.
`ifndef IN_PLANE_DIRECTION_CRAMER_SOLVE_DEFINES_SVH
`define IN_PLANE_DIRECTION_CRAMER_SOLVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IPDCS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPDCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ipdcs_pkg.sv */
// Shared types, widths, constants and arithmetic helpers of the direction solver.
package ipdcs_pkg;

    localparam int FRAC_BITS = 30;
    localparam int IN_W      = 32;
    localparam int TOL_W     = 31;
    localparam int N_W       = 35;   // plane normal components
    localparam int UW_W      = 37;   // c x n and n x r components
    localparam int D_W       = 40;   // determinant and numerators
    localparam int MAG_W     = 39;   // magnitudes of determinant and numerators
    localparam int PN_W      = 64;   // products for the normal
    localparam int PU_W      = 66;   // products for c x n and n x r
    localparam int PD_W      = 69;   // products for determinant and numerators
    localparam int MUL_W     = 40;
    localparam int PROD_W    = 80;
    localparam int Q_W       = 31;   // quotient magnitude bits
    localparam int STEPS     = 31;   // one quotient bit per divider stage
    localparam int FRONT_STAGES = 8;

    localparam logic [TOL_W-1:0] TOL_RESET = 31'd107;
    localparam logic [IN_W-1:0]  SAT_POS   = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0]  SAT_NEG   = 32'h8000_0000;

    // One classified solve, handed from the front to the divider.
    typedef struct packed {
        logic                       ok;
        logic [2:0]                 clip;
        logic [2:0]                 neg;
        logic [2:0][MAG_W-1:0]      num;
        logic [MAG_W-1:0]           den;
    } t_job;

    // What travels along the divider beside the partial remainders.
    typedef struct packed {
        logic                       ok;
        logic [2:0]                 clip;
        logic [2:0]                 neg;
        logic [MAG_W-1:0]           den;
    } t_meta;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Exact signed product.
    function automatic logic signed [PROD_W-1:0] mul(
        input logic signed [MUL_W-1:0] a,
        input logic signed [MUL_W-1:0] b
    );
        return a * b;
    endfunction

    // Drop FRAC_BITS fraction bits, rounding half away from zero.
    function automatic logic signed [PROD_W-1:0] qround(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        m = p[PROD_W-1] ? -p : p;
        r = (m + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p[PROD_W-1] ? -r : r;
    endfunction

endpackage

/* rtl/ipdcs_front.sv */
// Front pipeline: cross products, determinant, numerators and classification.
module ipdcs_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_row_x,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_row_y,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_row_z,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_col_x,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_col_y,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_col_z,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_cos_term,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_sin_term,
    input  logic [ipdcs_pkg::TOL_W-1:0]          i_tol,
    output logic                                 o_valid,
    output ipdcs_pkg::t_job                      o_job,
    output logic [3:0]                           o_inflight
);

    localparam int NS = ipdcs_pkg::FRONT_STAGES;

    logic [NS-1:0] r_vld;

    // Stage 0: input registers.
    logic signed [ipdcs_pkg::IN_W-1:0] r_row0 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_col0 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_cs0, r_sn0;
    // Stage 1: normal products.
    logic signed [ipdcs_pkg::PN_W-1:0] r_pna [3];
    logic signed [ipdcs_pkg::PN_W-1:0] r_pnb [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_row1 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_col1 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_cs1, r_sn1;
    // Stage 2: normal.
    logic signed [ipdcs_pkg::N_W-1:0]  r_nrm [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_row2 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_col2 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_cs2, r_sn2;
    // Stage 3: products for c x n and n x r.
    logic signed [ipdcs_pkg::PU_W-1:0] r_pua [3];
    logic signed [ipdcs_pkg::PU_W-1:0] r_pub [3];
    logic signed [ipdcs_pkg::PU_W-1:0] r_pwa [3];
    logic signed [ipdcs_pkg::PU_W-1:0] r_pwb [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_row3 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_cs3, r_sn3;
    // Stage 4: c x n and n x r.
    logic signed [ipdcs_pkg::UW_W-1:0] r_u [3];
    logic signed [ipdcs_pkg::UW_W-1:0] r_w [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_row4 [3];
    logic signed [ipdcs_pkg::IN_W-1:0] r_cs4, r_sn4;
    // Stage 5: products for the determinant and the numerators.
    logic signed [ipdcs_pkg::PD_W-1:0] r_pd [3];
    logic signed [ipdcs_pkg::PD_W-1:0] r_pc [3];
    logic signed [ipdcs_pkg::PD_W-1:0] r_ps [3];
    // Stage 6: determinant and numerators.
    logic signed [ipdcs_pkg::D_W-1:0]  r_delta;
    logic signed [ipdcs_pkg::D_W-1:0]  r_num [3];
    // Stage 7: classified job.
    ipdcs_pkg::t_job                   r_job;

    logic [ipdcs_pkg::MAG_W-1:0] w_dmag;
    logic [ipdcs_pkg::MAG_W-1:0] w_nmag [3];
    logic                        w_ok;

    // Valid bits move down the pipeline every cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // Stage 0 and the carried operands.
    always_ff @(posedge i_clk) begin
        r_row0 <= '{i_row_x, i_row_y, i_row_z};
        r_col0 <= '{i_col_x, i_col_y, i_col_z};
        r_cs0  <= i_cos_term;
        r_sn0  <= i_sin_term;
        r_row1 <= r_row0;  r_col1 <= r_col0;  r_cs1 <= r_cs0;  r_sn1 <= r_sn0;
        r_row2 <= r_row1;  r_col2 <= r_col1;  r_cs2 <= r_cs1;  r_sn2 <= r_sn1;
        r_row3 <= r_row2;  r_cs3 <= r_cs2;  r_sn3 <= r_sn2;
        r_row4 <= r_row3;  r_cs4 <= r_cs3;  r_sn4 <= r_sn3;
    end

    // Per-component cross products and the dot product terms.
    for (genvar g = 0; g < 3; g++) begin : g_comp
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        always_ff @(posedge i_clk) begin
            r_pna[g] <= ipdcs_pkg::PN_W'(ipdcs_pkg::mul(r_row0[J], r_col0[K]));
            r_pnb[g] <= ipdcs_pkg::PN_W'(ipdcs_pkg::mul(r_row0[K], r_col0[J]));
            r_nrm[g] <= ipdcs_pkg::N_W'(ipdcs_pkg::qround(r_pna[g])
                                        - ipdcs_pkg::qround(r_pnb[g]));
            r_pua[g] <= ipdcs_pkg::PU_W'(ipdcs_pkg::mul(r_col2[J], r_nrm[K]));
            r_pub[g] <= ipdcs_pkg::PU_W'(ipdcs_pkg::mul(r_col2[K], r_nrm[J]));
            r_pwa[g] <= ipdcs_pkg::PU_W'(ipdcs_pkg::mul(r_nrm[J], r_row2[K]));
            r_pwb[g] <= ipdcs_pkg::PU_W'(ipdcs_pkg::mul(r_nrm[K], r_row2[J]));
            r_u[g]   <= ipdcs_pkg::UW_W'(ipdcs_pkg::qround(r_pua[g])
                                         - ipdcs_pkg::qround(r_pub[g]));
            r_w[g]   <= ipdcs_pkg::UW_W'(ipdcs_pkg::qround(r_pwa[g])
                                         - ipdcs_pkg::qround(r_pwb[g]));
            r_pd[g]  <= ipdcs_pkg::PD_W'(ipdcs_pkg::mul(r_row4[g], r_u[g]));
            r_pc[g]  <= ipdcs_pkg::PD_W'(ipdcs_pkg::mul(r_cs4, r_u[g]));
            r_ps[g]  <= ipdcs_pkg::PD_W'(ipdcs_pkg::mul(r_sn4, r_w[g]));
            r_num[g] <= ipdcs_pkg::D_W'(ipdcs_pkg::qround(r_pc[g])
                                        + ipdcs_pkg::qround(r_ps[g]));
        end
        assign w_nmag[g] = ipdcs_pkg::MAG_W'(r_num[g][ipdcs_pkg::D_W-1] ? -r_num[g] : r_num[g]);
    end

    // The determinant is the sum of the three rounded terms.
    always_ff @(posedge i_clk) begin
        r_delta <= ipdcs_pkg::D_W'(ipdcs_pkg::qround(r_pd[0]) + ipdcs_pkg::qround(r_pd[1])
                                   + ipdcs_pkg::qround(r_pd[2]));
    end

    // Classification: singular test, signs, magnitudes and early overflow.
    assign w_dmag = ipdcs_pkg::MAG_W'(r_delta[ipdcs_pkg::D_W-1] ? -r_delta : r_delta);
    assign w_ok   = (w_dmag != '0) &&
                    (w_dmag >= ipdcs_pkg::MAG_W'(i_tol));

    always_ff @(posedge i_clk) begin
        r_job.ok  <= w_ok;
        r_job.den <= w_dmag;
        for (int i = 0; i < 3; i++) begin
            r_job.num[i]  <= w_nmag[i];
            r_job.neg[i]  <= r_num[i][ipdcs_pkg::D_W-1] ^ r_delta[ipdcs_pkg::D_W-1];
            r_job.clip[i] <= {1'b0, w_nmag[i]} >= {w_dmag, 1'b0};
        end
    end

    assign o_valid    = r_vld[NS-1];
    assign o_job      = r_job;
    assign o_inflight = 4'($countones(r_vld));

endmodule

/* rtl/ipdcs_fifo.sv */
// Short job queue between the front pipeline and the divider.
`include "in_plane_direction_cramer_solve_defines.svh"
module ipdcs_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  ipdcs_pkg::t_job              i_data,
    input  logic                         i_pop,
    output ipdcs_pkg::t_job              o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_level,
    output ipdcs_pkg::t_q_status         o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    ipdcs_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [LW-1:0]   r_level;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + LW'(1);
            end else if (!i_push && i_pop) begin
                r_level <= r_level - LW'(1);
            end
        end
    end

    assign o_data       = r_mem[r_rptr];
    assign o_level      = r_level;
    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == LW'(DEPTH));

    `IPDCS_ASSERT_IMP(a_no_overflow, i_push && !i_pop, r_level < LW'(DEPTH), "queue overflow")
    `IPDCS_ASSERT_IMP(a_no_underflow, i_pop, r_level != '0, "queue underflow")
    `IPDCS_ASSERT_NEXT(a_level_up, i_push && !i_pop, r_level == $past(r_level) + LW'(1), "level")

endmodule

/* rtl/ipdcs_back.sv */
// Back end: pipelined restoring divider, one quotient bit per stage, and result register.
module ipdcs_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  ipdcs_pkg::t_job                      i_job,
    output logic                                 o_done,
    output logic signed [ipdcs_pkg::IN_W-1:0]    o_dir_x,
    output logic signed [ipdcs_pkg::IN_W-1:0]    o_dir_y,
    output logic signed [ipdcs_pkg::IN_W-1:0]    o_dir_z,
    output logic                                 o_solvable,
    output logic                                 o_clipped
);

    localparam int ST = ipdcs_pkg::STEPS;
    localparam int MW = ipdcs_pkg::MAG_W;
    localparam int QW = ipdcs_pkg::Q_W;

    logic [ST-1:0]         r_vld;
    ipdcs_pkg::t_meta      r_meta [ST];
    logic [MW-1:0]         r_rem  [ST][3];
    logic [QW-1:0]         r_quo  [ST][3];

    logic                  r_done;
    logic [ipdcs_pkg::IN_W-1:0] r_dir [3];
    logic                  r_ok, r_clip;

    // Valid bits of the divider stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[ST-2:0], i_valid};
            r_done <= r_vld[ST-1];
        end
    end

    // Each stage decides one quotient bit for all three components.
    for (genvar j = 0; j < ST; j++) begin : g_step
        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                r_meta[0] <= '{ok: i_job.ok, clip: i_job.clip, neg: i_job.neg, den: i_job.den};
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                r_meta[j] <= r_meta[j-1];
            end
        end
        for (genvar g = 0; g < 3; g++) begin : g_lane
            logic [MW:0]     w_t;
            logic [MW-1:0]   w_den;
            logic [QW-1:0]   w_q;
            logic            w_bit;
            if (j == 0) begin : g_src0
                assign w_t   = {1'b0, i_job.num[g]};
                assign w_den = i_job.den;
                assign w_q   = '0;
            end else begin : g_srcn
                assign w_t   = {r_rem[j-1][g], 1'b0};
                assign w_den = r_meta[j-1].den;
                assign w_q   = r_quo[j-1][g];
            end
            assign w_bit = w_t >= {1'b0, w_den};
            always_ff @(posedge i_clk) begin
                r_rem[j][g] <= MW'(w_bit ? w_t - {1'b0, w_den} : w_t);
                r_quo[j][g] <= {w_q[QW-2:0], w_bit};
            end
        end
    end

    // Result formatting: sign, saturation and the singular case.
    always_ff @(posedge i_clk) begin
        r_ok   <= r_meta[ST-1].ok;
        r_clip <= r_meta[ST-1].ok && (r_meta[ST-1].clip != '0);
        for (int i = 0; i < 3; i++) begin
            if (!r_meta[ST-1].ok) begin
                r_dir[i] <= '0;
            end else if (r_meta[ST-1].clip[i]) begin
                r_dir[i] <= r_meta[ST-1].neg[i] ? ipdcs_pkg::SAT_NEG : ipdcs_pkg::SAT_POS;
            end else if (r_meta[ST-1].neg[i]) begin
                r_dir[i] <= -{1'b0, r_quo[ST-1][i]};
            end else begin
                r_dir[i] <= {1'b0, r_quo[ST-1][i]};
            end
        end
    end

    assign o_done     = r_done;
    assign o_dir_x    = r_dir[0];
    assign o_dir_y    = r_dir[1];
    assign o_dir_z    = r_dir[2];
    assign o_solvable = r_ok;
    assign o_clipped  = r_clip;

endmodule

/* rtl/in_plane_direction_cramer_solve.sv */
// Top level of the in-plane direction solver.
//
// Usage: present a beat on i_row_*, i_col_*, i_cos_term and i_sin_term with
// i_start high; it is taken at a rising edge where o_busy is low. The block
// forms n = row x col and solves row.d = cos, col.d = sin, n.d = 0 by
// Cramer's rule, all in signed Q2.30.
// One result beat per input beat, in order, marked by o_done for exactly one
// cycle; the receiver cannot hold it off and must take it then.
// Path: the accepting edge loads the first of 8 front stages; a beat then
// passes the queue, 31 divider stages and one result register before o_done
// rises.
// Throughput: one beat per cycle while o_busy stays low, set by the fully
// pipelined front and the one-bit-per-stage divider. o_busy rises only if
// the queue plus the front pipeline could fill QUEUE_DEPTH, which needs
// QUEUE_DEPTH of at least 10 to stay low in steady streaming.
// Configuration: i_cfg_we writes the 31-bit singular tolerance; write it only
// while no beat is in flight. Reset (synchronous, active low) empties the
// pipeline and queue and loads a tolerance of 107.
`include "in_plane_direction_cramer_solve_defines.svh"
module in_plane_direction_cramer_solve #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    output logic                                 o_busy,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_row_x,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_row_y,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_row_z,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_col_x,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_col_y,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_col_z,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_cos_term,
    input  logic signed [ipdcs_pkg::IN_W-1:0]    i_sin_term,
    input  logic                                 i_cfg_we,
    input  logic [ipdcs_pkg::TOL_W-1:0]          i_cfg_wdata,
    output logic                                 o_done,
    output logic signed [ipdcs_pkg::IN_W-1:0]    o_dir_x,
    output logic signed [ipdcs_pkg::IN_W-1:0]    o_dir_y,
    output logic signed [ipdcs_pkg::IN_W-1:0]    o_dir_z,
    output logic                                 o_solvable,
    output logic                                 o_clipped
);

    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = LW + 4;

    logic [ipdcs_pkg::TOL_W-1:0] r_tol;
    logic                        w_accept;
    logic                        w_f_valid;
    ipdcs_pkg::t_job             w_f_job;
    logic [3:0]                  w_inflight;
    ipdcs_pkg::t_job             w_q_job;
    logic [LW-1:0]               w_q_level;
    ipdcs_pkg::t_q_status        w_q_stat;
    logic                        w_pop;
    logic                        w_dir_zero;

    // Tolerance register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= ipdcs_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_wdata;
        end
    end

    // Hold off new beats when every queue slot is already claimed.
    assign o_busy   = (SW'(w_q_level) + SW'(w_inflight)) >= SW'(QUEUE_DEPTH);
    assign w_accept = i_start && !o_busy;
    assign w_pop    = !w_q_stat.empty;

    ipdcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_accept),
        .i_row_x    (i_row_x),
        .i_row_y    (i_row_y),
        .i_row_z    (i_row_z),
        .i_col_x    (i_col_x),
        .i_col_y    (i_col_y),
        .i_col_z    (i_col_z),
        .i_cos_term (i_cos_term),
        .i_sin_term (i_sin_term),
        .i_tol      (r_tol),
        .o_valid    (w_f_valid),
        .o_job      (w_f_job),
        .o_inflight (w_inflight)
    );

    ipdcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_data  (w_f_job),
        .i_pop   (w_pop),
        .o_data  (w_q_job),
        .o_level (w_q_level),
        .o_stat  (w_q_stat)
    );

    ipdcs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_pop),
        .i_job      (w_q_job),
        .o_done     (o_done),
        .o_dir_x    (o_dir_x),
        .o_dir_y    (o_dir_y),
        .o_dir_z    (o_dir_z),
        .o_solvable (o_solvable),
        .o_clipped  (o_clipped)
    );

    // All three result components are zero.
    assign w_dir_zero = (o_dir_x == '0) && (o_dir_y == '0) && (o_dir_z == '0);

    `IPDCS_ASSERT_IMP(a_singular_zero, o_done && !o_solvable, w_dir_zero && !o_clipped, "singular")
    `IPDCS_ASSERT_IMP(a_clip_solvable, o_done && o_clipped, o_solvable, "clip without solve")
    `IPDCS_ASSERT_IMP(a_full_busy, w_q_stat.full, o_busy, "queue full while not busy")

endmodule
